// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pdhtc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdhtc_pkg
// types and constants of the pd heading turn controller
// ----------------------------------------------------------------------------
`default_nettype none

package pdhtc_pkg;

    localparam int GAIN_SHIFT = 8;

    // angles in 1/64 degree
    localparam logic signed [16:0] FULL_TURN = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;

    localparam int SUM_W = 35;

    // register reset values
    localparam logic signed [14:0] TURN_TARGET_RST = 15'sd5760;
    localparam logic [15:0] P_GAIN_RST      = 16'd364;
    localparam logic [15:0] D_GAIN_RST      = 16'd364;
    localparam logic [14:0] MAX_STEER_RST   = 15'd11469;
    localparam logic [14:0] MIN_STEER_RST   = 15'd1638;
    localparam logic [14:0] STALL_LIMIT_RST = 15'd26;
    localparam logic [14:0] DONE_WINDOW_RST = 15'd384;
    localparam logic [2:0]  DONE_COUNT_RST  = 3'd2;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_TURN_TARGET = 3'd0,
        REG_P_GAIN      = 3'd1,
        REG_D_GAIN      = 3'd2,
        REG_MAX_STEER   = 3'd3,
        REG_MIN_STEER   = 3'd4,
        REG_STALL_LIMIT = 3'd5,
        REG_DONE_WINDOW = 3'd6,
        REG_DONE_COUNT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [14:0] turn_target;
        logic [15:0]        p_gain;
        logic [15:0]        d_gain;
        logic [14:0]        max_steer;
        logic [14:0]        min_steer;
        logic [14:0]        stall_limit;
        logic [14:0]        done_window;
        logic [2:0]         done_count;
    } cfg_t;

    // heading terms handed from the angle stage to the steer logic
    typedef struct packed {
        logic signed [14:0] turned;
        logic signed [15:0] err;
        logic signed [16:0] derr;
        logic               stall;
    } angle_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdhtc_angle.sv =====
// ----------------------------------------------------------------------------
// pdhtc_angle
// heading wrap, error, error change and stall detect
// ----------------------------------------------------------------------------
`default_nettype none

module pdhtc_angle (
    input  wire logic [14:0]        heading,
    input  wire logic [14:0]        reference_heading,
    input  wire logic signed [15:0] previous_error,
    input  wire logic signed [14:0] previous_turned,
    input  wire logic signed [14:0] turn_target,
    input  wire logic [14:0]        stall_limit,
    output pdhtc_pkg::angle_t       angle
);
    import pdhtc_pkg::*;

    logic signed [16:0] rel;
    logic signed [16:0] rel_pos;
    logic signed [16:0] rel_wrap;
    logic signed [14:0] turned;
    logic signed [15:0] err;
    logic signed [15:0] move;
    logic [15:0]        move_mag;

    // relative heading into one signed half turn
    assign rel      = $signed({2'b00, heading}) - $signed({2'b00, reference_heading});
    assign rel_pos  = (rel < 17'sd0) ? rel + FULL_TURN : rel;
    assign rel_wrap = (rel_pos > HALF_TURN) ? rel_pos - FULL_TURN : rel_pos;
    assign turned   = rel_wrap[14:0];

    assign err      = {turn_target[14], turn_target} - {turned[14], turned};

    assign move     = {turned[14], turned} - {previous_turned[14], previous_turned};
    assign move_mag = move[15] ? 16'(-move) : 16'(move);

    assign angle.turned = turned;
    assign angle.err    = err;
    assign angle.derr   = {previous_error[15], previous_error} - {err[15], err};
    assign angle.stall  = move_mag < {1'b0, stall_limit};

endmodule

`default_nettype wire

// ===== rtl/core/pdhtc_steer.sv =====
// ----------------------------------------------------------------------------
// pdhtc_steer
// pd steer with clamp to the maximum and lift to the minimum
// ----------------------------------------------------------------------------
`default_nettype none

module pdhtc_steer (
    input  wire pdhtc_pkg::angle_t  angle,
    input  wire logic [15:0]        p_gain,
    input  wire logic [15:0]        d_gain,
    input  wire logic [14:0]        max_steer,
    input  wire logic [14:0]        min_steer,
    output logic signed [15:0]      steer
);
    import pdhtc_pkg::*;

    logic signed [32:0]      prod_p;
    logic signed [33:0]      prod_d;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] mx_wide;
    logic signed [15:0]      mx;
    logic signed [15:0]      mn;
    logic signed [15:0]      clamped;

    assign prod_p  = angle.err * $signed({1'b0, p_gain});
    assign prod_d  = angle.derr * $signed({1'b0, d_gain});
    assign sum     = SUM_W'(prod_p) + SUM_W'(prod_d);
    // arithmetic shift rounds toward minus infinity
    assign shifted = sum >>> GAIN_SHIFT;

    assign mx_wide = $signed({{(SUM_W-15){1'b0}}, max_steer});
    assign mx      = $signed({1'b0, max_steer});
    assign mn      = angle.stall ? mx : $signed({1'b0, min_steer});

    always_comb
    begin
        priority if (shifted > mx_wide)
        begin
            clamped = mx;
        end
        else if (shifted < -mx_wide)
        begin
            clamped = -mx;
        end
        else
        begin
            clamped = shifted[15:0];
        end
    end

    // lift small values away from zero, zero goes positive
    always_comb
    begin
        if (clamped > -mn && clamped < mn)
        begin
            steer = clamped[15] ? -mn : mn;
        end
        else
        begin
            steer = clamped;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pd_heading_turn_controller.sv =====
// ----------------------------------------------------------------------------
// pd_heading_turn_controller
// turn-in-place heading controller: pd steer with output clamp
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                                      transfer
//  in        sink       in_valid/in_ready, opcode, heading           valid & ready
//  out       source     out_valid/out_ready, left_power,             valid & ready
//                       right_power, turned, done_res
//  cfg       sink       cfg_valid/cfg_ready, cfg_index, cfg_data     valid & ready
//
//  an input transfer is registered in the input register, then passes once
//  through wrap, two multipliers and clamp into the result register
//  one item per cycle is sustained while the output is not stalled; the pd
//  multiply-add sets the cycle time
//  reset (rst_n, asynchronous) empties both stages, loads register defaults and
//  clears the heading state; cfg_ready is always high
//  a stalled output holds the result and the input register keeps one more item
//
`default_nettype none

module pd_heading_turn_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic [14:0]        heading,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      left_power,
    output logic signed [15:0]      right_power,
    output logic signed [14:0]      turned,
    output logic                    done_res,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import pdhtc_pkg::*;

    // configuration registers
    cfg_t               cfg_reg;

    // input register
    logic               s1_valid_reg;
    opcode_t            s1_op_reg;
    logic [14:0]        s1_heading_reg;

    // heading state carried from item to item
    logic [14:0]        reference_heading_reg;
    logic signed [15:0] previous_error_reg;
    logic signed [14:0] previous_turned_reg;
    logic [2:0]         in_range_count_reg;
    logic [2:0]         in_range_count_next;

    // result register
    logic               out_valid_reg;
    logic signed [15:0] left_power_reg;
    logic signed [14:0] turned_reg;
    logic               done_res_reg;

    logic               out_free;
    logic               fire;
    angle_t             angle;
    logic signed [15:0] steer;
    logic [15:0]        err_mag;
    logic               in_range;

    // handshake: the result stage frees when empty or when its transfer completes
    assign out_free  = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    pdhtc_angle u_angle (
        .heading           (s1_heading_reg),
        .reference_heading (reference_heading_reg),
        .previous_error    (previous_error_reg),
        .previous_turned   (previous_turned_reg),
        .turn_target       (cfg_reg.turn_target),
        .stall_limit       (cfg_reg.stall_limit),
        .angle             (angle)
    );

    pdhtc_steer u_steer (
        .angle     (angle),
        .p_gain    (cfg_reg.p_gain),
        .d_gain    (cfg_reg.d_gain),
        .max_steer (cfg_reg.max_steer),
        .min_steer (cfg_reg.min_steer),
        .steer     (steer)
    );

    // in-range count saturates at its maximum, cleared on any miss
    assign err_mag  = angle.err[15] ? 16'(-angle.err) : 16'(angle.err);
    assign in_range = err_mag < {1'b0, cfg_reg.done_window};

    always_comb
    begin
        if (!in_range)
        begin
            in_range_count_next = 3'd0;
        end
        else if (in_range_count_reg == COUNT_MAX)
        begin
            in_range_count_next = COUNT_MAX;
        end
        else
        begin
            in_range_count_next = in_range_count_reg + 3'd1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_target <= TURN_TARGET_RST;
            cfg_reg.p_gain      <= P_GAIN_RST;
            cfg_reg.d_gain      <= D_GAIN_RST;
            cfg_reg.max_steer   <= MAX_STEER_RST;
            cfg_reg.min_steer   <= MIN_STEER_RST;
            cfg_reg.stall_limit <= STALL_LIMIT_RST;
            cfg_reg.done_window <= DONE_WINDOW_RST;
            cfg_reg.done_count  <= DONE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TURN_TARGET: cfg_reg.turn_target <= $signed(cfg_data[14:0]);
                REG_P_GAIN:      cfg_reg.p_gain      <= cfg_data;
                REG_D_GAIN:      cfg_reg.d_gain      <= cfg_data;
                REG_MAX_STEER:   cfg_reg.max_steer   <= cfg_data[14:0];
                REG_MIN_STEER:   cfg_reg.min_steer   <= cfg_data[14:0];
                REG_STALL_LIMIT: cfg_reg.stall_limit <= cfg_data[14:0];
                REG_DONE_WINDOW: cfg_reg.done_window <= cfg_data[14:0];
                REG_DONE_COUNT:  cfg_reg.done_count  <= cfg_data[2:0];
            endcase
        end
    end

    // stage valid flags and heading state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            reference_heading_reg <= '0;
            previous_error_reg    <= '0;
            previous_turned_reg   <= '0;
            in_range_count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                if (s1_op_reg == OP_START)
                begin
                    // start keeps the previous turned value
                    reference_heading_reg <= s1_heading_reg;
                    previous_error_reg    <= {cfg_reg.turn_target[14], cfg_reg.turn_target};
                    in_range_count_reg    <= 3'd0;
                end
                else
                begin
                    previous_error_reg    <= angle.err;
                    previous_turned_reg   <= angle.turned;
                    in_range_count_reg    <= in_range_count_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg      <= opcode_t'(opcode);
            s1_heading_reg <= heading;
        end
        if (fire)
        begin
            if (s1_op_reg == OP_START)
            begin
                left_power_reg <= '0;
                turned_reg     <= '0;
                done_res_reg   <= 1'b0;
            end
            else
            begin
                left_power_reg <= steer;
                turned_reg     <= angle.turned;
                done_res_reg   <= in_range_count_next >= cfg_reg.done_count;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_power  = left_power_reg;
    assign right_power = -left_power_reg;
    assign turned      = turned_reg;
    assign done_res    = done_res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pdhtc_checker.sv =====
// ----------------------------------------------------------------------------
// pdhtc_checker
// port-level checks of the heading turn controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pdhtc_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] left_power,
    input  wire logic signed [15:0] right_power,
    input  wire logic signed [14:0] turned,
    input  wire logic               done_res
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_power) && $stable(turned) && $stable(done_res), "stalled result changed")

    // wheels always opposite while out_valid is high
    `ASSERT_ALWAYS(a_wheels_opposite, !out_valid || (left_power + right_power) == 16'sd0, "wheel powers not opposite")

    // power never reaches the negative full scale
    `ASSERT_ALWAYS(a_power_range, !out_valid || left_power != -16'sd32768, "power out of range")

    // relative heading stays within a half turn
    `ASSERT_ALWAYS(a_turned_range, !out_valid || (turned >= -15'sd11520 && turned <= 15'sd11520), "turned out of range")

endmodule

bind pd_heading_turn_controller pdhtc_checker u_pdhtc_checker (.*);

`default_nettype wire
